[hw/rtl/id3fw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame walker package
// Event codes and the result beat type shared by the walker modules.
// ----------------------------------------------------------------------------
package id3fw_pkg;

    typedef enum logic [1:0] {
        EV_TAG_HDR   = 2'd0,
        EV_FRAME_HDR = 2'd1,
        EV_CONTENT   = 2'd2,
        EV_TAG_END   = 2'd3
    } t_event;

    localparam int HDR_LEN = 10;
    localparam int IDX_W = 4;
    localparam int TAG_SIZE_W = 28;

    typedef struct packed {
        t_event                  event_res;
        logic [7:0]              major_version;
        logic [7:0]              revision;
        logic [7:0]              header_flags;
        logic [TAG_SIZE_W-1:0]   tag_size;
        logic [31:0]             frame_id;
        logic [31:0]             frame_size;
        logic [15:0]             frame_flags;
        logic [7:0]              content_byte;
        logic                    last_content;
        logic                    end_reason;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/id3v2_tag_frame_walker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 tag frame walker
// Parses an ID3v2 tag header and walks its frames, one file byte per beat.
//
//   Channel  Direction  Handshake            Payload
//   input    in         i_valid / o_stall    i_data_byte, i_start_of_file
//   output   out        o_valid / i_stall    o_event_res and the event fields
//
// Each accepted byte beat's result, if any, is registered in the output
// stage; one beat per cycle is sustained while o_stall is low.
// The walk state updates in the accepting cycle, so no stage holds a byte.
// The output register has a skid entry behind it; o_stall rises only when
// that entry is occupied, and is a register.
// Reset is synchronous and returns the parser to tag header collection.
// ----------------------------------------------------------------------------
module id3v2_tag_frame_walker_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_start_of_file,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_event_res,
    output logic [7:0]                         o_major_version,
    output logic [7:0]                         o_revision,
    output logic [7:0]                         o_header_flags,
    output logic [id3fw_pkg::TAG_SIZE_W-1:0]   o_tag_size,
    output logic [31:0]                        o_frame_id,
    output logic [31:0]                        o_frame_size,
    output logic [15:0]                        o_frame_flags,
    output logic [7:0]                         o_content_byte,
    output logic                               o_last_content,
    output logic                               o_end_reason
);
    import id3fw_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    logic    w_full;
    t_result w_res;
    t_result w_out;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    id3fw_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_accept),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    id3fw_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_accept && w_res_valid),
        .i_res       (w_res),
        .o_full      (w_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (w_out)
    );

    assign o_event_res     = w_out.event_res;
    assign o_major_version = w_out.major_version;
    assign o_revision      = w_out.revision;
    assign o_header_flags  = w_out.header_flags;
    assign o_tag_size      = w_out.tag_size;
    assign o_frame_id      = w_out.frame_id;
    assign o_frame_size    = w_out.frame_size;
    assign o_frame_flags   = w_out.frame_flags;
    assign o_content_byte  = w_out.content_byte;
    assign o_last_content  = w_out.last_content;
    assign o_end_reason    = w_out.end_reason;

endmodule
`default_nettype wire

[hw/rtl/id3fw_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame walker parser
// Holds the walk state and turns each accepted byte into at most one result.
// ----------------------------------------------------------------------------
module id3fw_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_start_of_file,
    output logic                   o_res_valid,
    output id3fw_pkg::t_result     o_res
);
    import id3fw_pkg::*;

    typedef enum logic [1:0] {
        PH_TAGHDR  = 2'd0,
        PH_FRMHDR  = 2'd1,
        PH_CONTENT = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_LEN - 1);

    t_phase                 r_phase, n_phase;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [TAG_SIZE_W-1:0]  r_tag_rem, n_tag_rem;
    logic [31:0]            r_frame_rem, n_frame_rem;
    logic [7:0]             r_hb [HDR_LEN];

    t_phase                 w_phase;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_hb_we;
    logic                   w_tag_zero;
    logic [TAG_SIZE_W-1:0]  w_tag_dec;
    logic [31:0]            w_frame_dec;
    logic [31:0]            w_frame_size;
    logic                   w_last;

    always_comb begin
        w_phase      = i_start_of_file ? PH_TAGHDR : r_phase;
        w_idx        = i_start_of_file ? '0 : r_idx;
        w_tag_zero   = (r_tag_rem == '0);
        w_tag_dec    = r_tag_rem - 1'b1;
        w_frame_dec  = (r_frame_rem != '0) ? r_frame_rem - 1'b1 : '0;
        w_frame_size = {r_hb[4], r_hb[5], r_hb[6], r_hb[7]};
        w_last       = (w_frame_dec == '0) || (w_tag_dec == '0);

        n_phase     = w_phase;
        n_idx       = w_idx;
        n_tag_rem   = r_tag_rem;
        n_frame_rem = r_frame_rem;
        w_hb_we     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (w_phase)
            PH_TAGHDR: begin
                w_hb_we = 1'b1;
                if (w_idx == LAST_IDX) begin
                    n_idx                = '0;
                    n_tag_rem            = {r_hb[6][6:0], r_hb[7][6:0],
                                            r_hb[8][6:0], i_data_byte[6:0]};
                    n_phase              = PH_FRMHDR;
                    o_res_valid          = 1'b1;
                    o_res.event_res      = EV_TAG_HDR;
                    o_res.major_version  = r_hb[3];
                    o_res.revision       = r_hb[4];
                    o_res.header_flags   = r_hb[5];
                    o_res.tag_size       = n_tag_rem;
                end else begin
                    n_idx = w_idx + 1'b1;
                end
            end
            PH_FRMHDR: begin
                if (w_tag_zero) begin
                    n_phase         = PH_DONE;
                    o_res_valid     = 1'b1;
                    o_res.event_res = EV_TAG_END;
                end else begin
                    w_hb_we   = 1'b1;
                    n_tag_rem = w_tag_dec;
                    if (w_idx == LAST_IDX) begin
                        n_idx = '0;
                        if (w_frame_size == '0) begin
                            n_phase          = PH_DONE;
                            o_res_valid      = 1'b1;
                            o_res.event_res  = EV_TAG_END;
                            o_res.end_reason = 1'b1;
                        end else begin
                            n_frame_rem       = w_frame_size;
                            n_phase           = PH_CONTENT;
                            o_res_valid       = 1'b1;
                            o_res.event_res   = EV_FRAME_HDR;
                            o_res.frame_id    = {r_hb[0], r_hb[1], r_hb[2], r_hb[3]};
                            o_res.frame_size  = w_frame_size;
                            o_res.frame_flags = {r_hb[8], i_data_byte};
                        end
                    end else begin
                        n_idx = w_idx + 1'b1;
                    end
                end
            end
            PH_CONTENT: begin
                o_res_valid = 1'b1;
                if (w_tag_zero) begin
                    n_phase         = PH_DONE;
                    o_res.event_res = EV_TAG_END;
                end else begin
                    n_tag_rem          = w_tag_dec;
                    n_frame_rem        = w_frame_dec;
                    o_res.event_res    = EV_CONTENT;
                    o_res.content_byte = i_data_byte;
                    o_res.last_content = w_last;
                    if (w_last) begin
                        n_phase = PH_FRMHDR;
                        n_idx   = '0;
                    end
                end
            end
            PH_DONE: begin
                o_res_valid = 1'b0;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAGHDR;
            r_idx       <= '0;
            r_tag_rem   <= '0;
            r_frame_rem <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_tag_rem   <= n_tag_rem;
            r_frame_rem <= n_frame_rem;
        end
        if (i_en && w_hb_we) begin
            r_hb[w_idx] <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/id3fw_out_skid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ID3v2 frame walker output stage
// Result register with a skid entry, so the input stall is a register.
// ----------------------------------------------------------------------------
module id3fw_out_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire id3fw_pkg::t_result i_res,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output id3fw_pkg::t_result     o_res
);
    import id3fw_pkg::*;

    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_take;

    assign w_take  = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || w_take) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ID3v2 tag frame walker testbench
// Feeds byte streams that hold tag headers, frames, padding, truncated files
// and noise into the walker. A predictor in this file follows the walk and
// queues the events it expects. The result beats are then checked against
// that queue, field by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import id3fw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES = 600;

    typedef enum logic [1:0] {
        WALK_TAG_HDR,
        WALK_FRAME_HDR,
        WALK_CONTENT,
        WALK_DONE
    } t_walk_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [7:0]            i_data_byte = '0;
    logic                  i_start_of_file = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_event_res;
    logic [7:0]            o_major_version;
    logic [7:0]            o_revision;
    logic [7:0]            o_header_flags;
    logic [TAG_SIZE_W-1:0] o_tag_size;
    logic [31:0]           o_frame_id;
    logic [31:0]           o_frame_size;
    logic [15:0]           o_frame_flags;
    logic [7:0]            o_content_byte;
    logic                  o_last_content;
    logic                  o_end_reason;

    // Predictor state.
    t_walk_phase walk_phase = WALK_TAG_HDR;
    int          hdr_idx = 0;
    logic [7:0]  hdr_buf [HDR_LEN];
    logic [28:0] tag_left = '0;
    logic [31:0] frame_left = '0;

    t_result     pending_events [$];
    int unsigned in_idle_pct = 24;
    int unsigned out_stall_pct = 24;
    int unsigned bytes_sent = 0;
    int unsigned walked_bytes = 0;
    int unsigned result_beats = 0;
    int unsigned files_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    id3v2_tag_frame_walker_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_res     (o_event_res),
        .o_major_version (o_major_version),
        .o_revision      (o_revision),
        .o_header_flags  (o_header_flags),
        .o_tag_size      (o_tag_size),
        .o_frame_id      (o_frame_id),
        .o_frame_size    (o_frame_size),
        .o_frame_flags   (o_frame_flags),
        .o_content_byte  (o_content_byte),
        .o_last_content  (o_last_content),
        .o_end_reason    (o_end_reason)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advances the walk by one byte and returns 1 when that byte yields an event.
    function automatic bit walk_byte(input logic [7:0] b, input logic sof,
                                     output t_result r);
        bit last;
        r = '0;
        if (sof) begin
            walk_phase = WALK_TAG_HDR;
            hdr_idx = 0;
        end
        if (walk_phase != WALK_DONE) begin
            walked_bytes++;
        end
        case (walk_phase)
            WALK_TAG_HDR: begin
                hdr_buf[hdr_idx] = b;
                hdr_idx++;
                if (hdr_idx < HDR_LEN) begin
                    return 1'b0;
                end
                hdr_idx = 0;
                tag_left = {1'b0, hdr_buf[6][6:0], hdr_buf[7][6:0],
                            hdr_buf[8][6:0], hdr_buf[9][6:0]};
                walk_phase = WALK_FRAME_HDR;
                r.event_res = EV_TAG_HDR;
                r.major_version = hdr_buf[3];
                r.revision = hdr_buf[4];
                r.header_flags = hdr_buf[5];
                r.tag_size = tag_left[TAG_SIZE_W-1:0];
                return 1'b1;
            end
            WALK_FRAME_HDR: begin
                if (tag_left == 0) begin
                    walk_phase = WALK_DONE;
                    r.event_res = EV_TAG_END;
                    return 1'b1;
                end
                hdr_buf[hdr_idx] = b;
                hdr_idx++;
                tag_left--;
                if (hdr_idx < HDR_LEN) begin
                    return 1'b0;
                end
                hdr_idx = 0;
                frame_left = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
                if (frame_left == 0) begin
                    walk_phase = WALK_DONE;
                    r.event_res = EV_TAG_END;
                    r.end_reason = 1'b1;
                    return 1'b1;
                end
                walk_phase = WALK_CONTENT;
                r.event_res = EV_FRAME_HDR;
                r.frame_id = {hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]};
                r.frame_size = frame_left;
                r.frame_flags = {hdr_buf[8], hdr_buf[9]};
                return 1'b1;
            end
            WALK_CONTENT: begin
                if (tag_left == 0) begin
                    walk_phase = WALK_DONE;
                    r.event_res = EV_TAG_END;
                    return 1'b1;
                end
                tag_left--;
                if (frame_left != 0) begin
                    frame_left--;
                end
                last = (frame_left == 0) || (tag_left == 0);
                if (last) begin
                    walk_phase = WALK_FRAME_HDR;
                    hdr_idx = 0;
                end
                r.event_res = EV_CONTENT;
                r.content_byte = b;
                r.last_content = last;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic sof);
        t_result r;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_start_of_file <= sof;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        if (walk_byte(b, sof, r)) begin
            pending_events.push_back(r);
        end
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_beats++;
            if (pending_events.size() == 0) begin
                $error("result beat with event %0d arrived with nothing expected",
                       o_event_res);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                compare_field("event_res", want.event_res, o_event_res);
                compare_field("major_version", want.major_version, o_major_version);
                compare_field("revision", want.revision, o_revision);
                compare_field("header_flags", want.header_flags, o_header_flags);
                compare_field("tag_size", want.tag_size, o_tag_size);
                compare_field("frame_id", want.frame_id, o_frame_id);
                compare_field("frame_size", want.frame_size, o_frame_size);
                compare_field("frame_flags", want.frame_flags, o_frame_flags);
                compare_field("content_byte", want.content_byte, o_content_byte);
                compare_field("last_content", want.last_content, o_last_content);
                compare_field("end_reason", want.end_reason, o_end_reason);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Straight out of reset, with no start of file: extreme header bytes, a
    // syncsafe size of zero with every top bit set, then the tag end and a
    // byte that must be ignored.
    task automatic test_empty_tag_without_sof();
        logic [7:0] hdr [HDR_LEN] = '{8'h49, 8'h44, 8'h33, 8'hFF, 8'hFF, 8'hFF,
                                      8'h80, 8'h80, 8'h80, 8'h80};
        foreach (hdr[i]) begin
            send_byte(hdr[i], 1'b0);
        end
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
    endtask

    // A tag of 13 bytes holding one frame with all-ones header fields, so the
    // tag runs out three bytes into the content.
    task automatic test_content_cut_at_tag_end();
        logic [7:0] hdr [HDR_LEN] = '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00,
                                      8'h80, 8'h80, 8'h80, 8'h8D};
        foreach (hdr[i]) begin
            send_byte(hdr[i], i == 0);
        end
        repeat (HDR_LEN) begin
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
    endtask

    // One file: a tag header with a small syncsafe size and random top bits,
    // then a run of frames that may hold padding, huge sizes and short
    // content. Some files are cut short, some lack the start mark, and some
    // are plain noise.
    task automatic send_random_file();
        logic [7:0]  tag_hdr [HDR_LEN];
        logic [7:0]  body [$];
        logic [27:0] tag_len;
        logic [31:0] fsize;
        int unsigned pick;
        int unsigned kind;
        int unsigned sent_len;
        logic        first_sof;
        files_sent++;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            repeat ($urandom_range(1, 30)) begin
                send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end
            return;
        end
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            tag_len = '0;
        end else if (pick == 2) begin
            tag_len = 28'($urandom_range(100, 300));
        end else begin
            tag_len = 28'($urandom_range(1, 60));
        end
        if ($urandom_range(0, 1)) begin
            tag_hdr[0] = 8'h49;
            tag_hdr[1] = 8'h44;
            tag_hdr[2] = 8'h33;
        end else begin
            for (int i = 0; i < 3; i++) begin
                tag_hdr[i] = 8'($urandom);
            end
        end
        for (int i = 3; i < 6; i++) begin
            tag_hdr[i] = 8'($urandom);
        end
        tag_hdr[6] = {1'($urandom), tag_len[27:21]};
        tag_hdr[7] = {1'($urandom), tag_len[20:14]};
        tag_hdr[8] = {1'($urandom), tag_len[13:7]};
        tag_hdr[9] = {1'($urandom), tag_len[6:0]};
        while (body.size() < tag_len + 3) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                fsize = '0;
            end else if (kind == 1) begin
                fsize = $urandom;
            end else begin
                fsize = $urandom_range(1, 12);
            end
            repeat (4) begin
                body.push_back(8'($urandom));
            end
            for (int i = 3; i >= 0; i--) begin
                body.push_back(fsize[8*i +: 8]);
            end
            repeat (2) begin
                body.push_back(8'($urandom));
            end
            repeat ((fsize > 16) ? 16 : fsize) begin
                body.push_back(8'($urandom));
            end
        end
        first_sof = ($urandom_range(0, 19) != 0);
        foreach (tag_hdr[i]) begin
            send_byte(tag_hdr[i], (i == 0) && first_sof);
        end
        sent_len = body.size();
        if ($urandom_range(0, 9) == 0) begin
            sent_len = $urandom_range(0, body.size());
        end
        for (int i = 0; i < sent_len; i++) begin
            send_byte(body[i], 1'b0);
        end
    endtask

    // The first stretch runs with neither side idling.
    task automatic test_random_files();
        int unsigned sent_at_start;
        sent_at_start = bytes_sent;
        while (bytes_sent - sent_at_start < RANDOM_BYTES) begin
            if (bytes_sent - sent_at_start < 200) begin
                in_idle_pct = 0;
                out_stall_pct = 0;
            end else begin
                in_idle_pct = 24;
                out_stall_pct = 24;
            end
            send_random_file();
        end
    endtask

    initial begin
        repeat (6) begin
            @(negedge i_clk);
        end
        i_rst_n <= 1'b1;
        test_empty_tag_without_sof();
        test_content_cut_at_tag_end();
        test_random_files();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) begin
            @(posedge i_clk);
        end
        $display("Sent %0d bytes (%0d walked) in two directed tags and %0d random files.",
                 bytes_sent, walked_bytes, files_sent);
        $display("Checked %0d result beats with %0d field mismatches.",
                 result_beats, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
